// ----- rtl/lidar_envelope_collision_check_assert.svh -----
// Assertion macros used by the lidar envelope collision check port checker.
// No dependencies; include by bare file name.
`ifndef LIDAR_ENVELOPE_COLLISION_CHECK_ASSERT_SVH
`define LIDAR_ENVELOPE_COLLISION_CHECK_ASSERT_SVH

// Clocked property, masked while reset is asserted.
`define LEC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define LEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lec_pkg.sv -----
// Shared types and constants of the lidar envelope collision check.
// No dependencies.
package lec_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHECK_ENABLE   = 3'd0,
        REG_SENSOR_HEIGHT  = 3'd1,
        REG_ENV_TANGENT    = 3'd2,
        REG_CORRIDOR_LEN   = 3'd3,
        REG_CORRIDOR_HALFW = 3'd4,
        REG_TRIGGER_COUNT  = 3'd5
    } reg_index_t;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic               RST_CHECK_ENABLE   = 1'b1;
    localparam logic signed [15:0] RST_SENSOR_HEIGHT  = 16'sd195;
    localparam logic [15:0]        RST_ENV_TANGENT    = 16'd17561;
    localparam logic [14:0]        RST_CORRIDOR_LEN   = 15'd1280;
    localparam logic [14:0]        RST_CORRIDOR_HALFW = 15'd256;
    localparam logic [15:0]        RST_TRIGGER_COUNT  = 16'd10;

    typedef struct packed {
        logic               check_enable;
        logic signed [15:0] sensor_height;
        logic [15:0]        envelope_tangent;
        logic [14:0]        corridor_reach;
        logic [14:0]        corridor_half_width;
        logic [15:0]        trigger_count;
    } cfg_t;

    // Per-point verdict handed from the point stage to the frame counters.
    typedef struct packed {
        logic valid;
        logic last;
        logic hazard;
        logic right;
    } point_flags_t;

endpackage

// ----- rtl/lec_cfg_regs.sv -----
// Configuration register file of the lidar envelope collision check.
// Depends on lec_pkg.
module lec_cfg_regs
    import lec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_CHECK_ENABLE:   cfg_next.check_enable        = cfg_data[0];
                REG_SENSOR_HEIGHT:  cfg_next.sensor_height       = $signed(cfg_data);
                REG_ENV_TANGENT:    cfg_next.envelope_tangent    = cfg_data;
                REG_CORRIDOR_LEN:   cfg_next.corridor_reach      = cfg_data[14:0];
                REG_CORRIDOR_HALFW: cfg_next.corridor_half_width = cfg_data[14:0];
                REG_TRIGGER_COUNT:  cfg_next.trigger_count       = cfg_data;
                default:            cfg_next = cfg_reg; // unknown index: drop
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_enable        <= RST_CHECK_ENABLE;
            cfg_reg.sensor_height       <= RST_SENSOR_HEIGHT;
            cfg_reg.envelope_tangent    <= RST_ENV_TANGENT;
            cfg_reg.corridor_reach      <= RST_CORRIDOR_LEN;
            cfg_reg.corridor_half_width <= RST_CORRIDOR_HALFW;
            cfg_reg.trigger_count       <= RST_TRIGGER_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/lec_point_stage.sv -----
// Input register and per-point envelope test of the collision check.
// Depends on lec_pkg.
module lec_point_stage
    import lec_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          last_point,
    input  logic                          advance,
    input  cfg_t                          cfg,
    output point_flags_t                  flags
);

    // Room for coordinate plus height sum and its negation.
    localparam int EXT_W = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;
    localparam int MUL_W = COORD_WIDTH + 16;
    localparam int CMP_W = EXT_W + 16;

    logic                          valid_reg, valid_next;
    logic                          last_reg;
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;

    logic signed [EXT_W-1:0] x_ext, y_ext, z_ext;
    logic signed [EXT_W-1:0] len_ext, hw_ext, hsum;
    logic [EXT_W-1:0]        hmag;
    logic [MUL_W-1:0]        slope;
    logic [CMP_W-1:0]        lhs, rhs;
    logic                    in_corridor;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg    <= point_x;
            y_reg    <= point_y;
            z_reg    <= point_z;
            last_reg <= last_point;
        end
    end

    assign x_ext   = EXT_W'(x_reg);
    assign y_ext   = EXT_W'(y_reg);
    assign z_ext   = EXT_W'(z_reg);
    assign len_ext = $signed(EXT_W'(cfg.corridor_reach));
    assign hw_ext  = $signed(EXT_W'(cfg.corridor_half_width));

    assign in_corridor = (x_ext > 0) && (x_ext < len_ext)
                      && (y_ext < hw_ext) && (y_ext > -hw_ext);

    assign hsum = EXT_W'(cfg.sensor_height) + z_ext;
    assign hmag = (hsum < 0) ? EXT_W'(-hsum) : EXT_W'(hsum);

    // x is positive whenever the product matters, so treat its bits as unsigned.
    assign slope = MUL_W'(COORD_WIDTH'(x_reg)) * MUL_W'(cfg.envelope_tangent);
    assign lhs   = {hmag, 16'b0};
    assign rhs   = CMP_W'(slope);

    assign flags.valid  = valid_reg;
    assign flags.last   = last_reg;
    assign flags.hazard = cfg.check_enable && in_corridor && (lhs > rhs);
    assign flags.right  = y_reg < 0;

endmodule

// ----- rtl/lec_frame_count.sv -----
// Frame hazard counters and result register of the collision check.
// Depends on lec_pkg.
module lec_frame_count
    import lec_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  point_flags_t           flags,
    input  logic                   advance,
    input  cfg_t                   cfg,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [1:0]             collision_side,
    output logic [COUNT_WIDTH-1:0] hazard_points,
    output logic [COUNT_WIDTH-1:0] left_points,
    output logic [COUNT_WIDTH-1:0] right_points
);

    localparam int TRIG_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] hazard_reg, hazard_next;
    logic [COUNT_WIDTH-1:0] left_reg, left_next;
    logic [COUNT_WIDTH-1:0] right_reg, right_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             side_reg, side_next;
    logic [COUNT_WIDTH-1:0] out_hazard_reg, out_left_reg, out_right_reg;
    logic                   inc, emit;

    assign inc  = advance && flags.hazard;
    assign emit = advance && flags.last;

    always_comb begin
        hazard_next = hazard_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        if (inc) begin
            if (hazard_reg != COUNT_MAX) begin
                hazard_next = hazard_reg + 1'b1;
            end
            if (flags.right) begin
                if (right_reg != COUNT_MAX) begin
                    right_next = right_reg + 1'b1;
                end
            end else if (left_reg != COUNT_MAX) begin
                left_next = left_reg + 1'b1;
            end
        end
    end

    // Side uses the counts including the closing point itself; ties go right.
    always_comb begin
        side_next = SIDE_NONE;
        if (cfg.check_enable && (TRIG_W'(hazard_next) > TRIG_W'(cfg.trigger_count))) begin
            side_next = (left_next > right_next) ? SIDE_LEFT : SIDE_RIGHT;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hazard_reg    <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (emit) begin
                hazard_reg <= '0;
                left_reg   <= '0;
                right_reg  <= '0;
            end else begin
                hazard_reg <= hazard_next;
                left_reg   <= left_next;
                right_reg  <= right_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            side_reg       <= side_next;
            out_hazard_reg <= hazard_next;
            out_left_reg   <= left_next;
            out_right_reg  <= right_next;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign collision_side = side_reg;
    assign hazard_points  = out_hazard_reg;
    assign left_points    = out_left_reg;
    assign right_points   = out_right_reg;

endmodule

// ----- rtl/lidar_envelope_collision_check.sv -----
// Top level of the lidar envelope collision check.
// Depends on lec_pkg, lec_cfg_regs, lec_point_stage and lec_frame_count.

// Accepts one lidar point per clock and tests it against the forward
// corridor and the safe envelope with a single coord-by-16-bit multiply;
// hazard points are counted per frame. The point on tlast passes the input
// register, then the result register, and produces one result transaction
// carrying the side verdict and the three saturating counts; it also clears
// the counters. Sustained rate is one point per cycle; only a frame-closing
// point waits, and only while the previous result is still held in the
// result register. Configuration writes are taken every cycle and should
// be issued only while no point is in flight.
module lidar_envelope_collision_check
    import lec_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // collision_side, hazard_points, left_points, right_points
    output logic [((2+3*COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int OUT_W = ((2 + 3*COUNT_WIDTH + 7) / 8) * 8;

    cfg_t                   cfg;
    point_flags_t           flags;
    logic                   load, advance;
    logic [1:0]             collision_side;
    logic [COUNT_WIDTH-1:0] hazard_points, left_points, right_points;

    // A frame-closing point waits while the result register is still full.
    assign advance  = flags.valid && !(flags.last && m_tvalid && !m_tready);
    assign s_tready = !flags.valid || advance;
    assign load     = s_tvalid && s_tready;

    lec_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lec_point_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_point (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .point_x    ($signed(s_tdata[COORD_WIDTH-1:0])),
        .point_y    ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .point_z    ($signed(s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
        .last_point (s_tlast),
        .advance    (advance),
        .cfg        (cfg),
        .flags      (flags)
    );

    lec_frame_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .flags          (flags),
        .advance        (advance),
        .cfg            (cfg),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .collision_side (collision_side),
        .hazard_points  (hazard_points),
        .left_points    (left_points),
        .right_points   (right_points)
    );

    assign m_tdata = OUT_W'({right_points, left_points, hazard_points, collision_side});

endmodule

// ----- rtl/lec_checker.sv -----
// Port-level checker for the lidar envelope collision check, with its bind.
// Depends on lec_pkg and lidar_envelope_collision_check_assert.svh.
`include "lidar_envelope_collision_check_assert.svh"

module lec_checker
    import lec_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [((2+3*COUNT_WIDTH+7)/8)*8-1:0]    m_tdata
);

    logic [1:0]             side;
    logic [COUNT_WIDTH-1:0] hazard, left, right;

    assign side   = m_tdata[1:0];
    assign hazard = m_tdata[2 +: COUNT_WIDTH];
    assign left   = m_tdata[2+COUNT_WIDTH +: COUNT_WIDTH];
    assign right  = m_tdata[2+2*COUNT_WIDTH +: COUNT_WIDTH];

    `LEC_ASSERT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result transaction changed")
    `LEC_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")
    `LEC_ASSERT(a_side_code, aclk, aresetn, m_tvalid |-> (side == SIDE_NONE || side == SIDE_LEFT || side == SIDE_RIGHT), "illegal collision side code")
    `LEC_ASSERT(a_split_le_total, aclk, aresetn, m_tvalid |-> (left <= hazard) && (right <= hazard), "side count exceeds hazard count")
    `LEC_ASSERT(a_left_majority, aclk, aresetn, m_tvalid && side == SIDE_LEFT |-> left > right && hazard != '0, "left verdict without left majority")

endmodule

bind lidar_envelope_collision_check lec_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_lec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/lec_frame_verdict_checker.sv -----
// Frame verdict checker for the lidar envelope collision check.
// Watches the point, result and configuration channels and predicts each result; uses lec_pkg.
module lec_frame_verdict_checker
    import lec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // point_x, point_y, point_z
    input  logic [47:0]           s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // collision_side, hazard_points, left_points, right_points
    input  logic [55:0]           m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    verdicts_pending,
    output int                    mismatches
);

    typedef struct packed {
        logic [1:0]  side;
        logic [15:0] hazard;
        logic [15:0] left;
        logic [15:0] right;
    } frame_verdict_t;

    cfg_t           shadow_cfg;
    logic [15:0]    hazard_cnt;
    logic [15:0]    left_cnt;
    logic [15:0]    right_cnt;
    frame_verdict_t verdicts_due[$];
    int             error_cnt = 0;

    // Compare |height + z| << 16 against x * tangent; wide enough to stay exact.
    function automatic logic point_is_hazard(logic signed [15:0] px, logic signed [15:0] py,
                                             logic signed [15:0] pz);
        longint x, y, z, h, half, reach, lhs, rhs;
        x     = px;
        y     = py;
        z     = pz;
        h     = $signed(shadow_cfg.sensor_height);
        half  = longint'(shadow_cfg.corridor_half_width);
        reach = longint'(shadow_cfg.corridor_reach);
        if (x <= 0 || x >= reach || y >= half || y <= -half)
            return 1'b0;
        lhs = h + z;
        if (lhs < 0)
            lhs = -lhs;
        lhs = lhs <<< 16;
        rhs = x * longint'(shadow_cfg.envelope_tangent);
        return lhs > rhs;
    endfunction

    function automatic logic [15:0] bump(logic [15:0] c);
        return (c == '1) ? c : c + 16'd1;
    endfunction

    always @(posedge aclk) begin : watch_channels
        frame_verdict_t     want;
        frame_verdict_t     got;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        if (!aresetn) begin
            shadow_cfg.check_enable        = RST_CHECK_ENABLE;
            shadow_cfg.sensor_height       = RST_SENSOR_HEIGHT;
            shadow_cfg.envelope_tangent    = RST_ENV_TANGENT;
            shadow_cfg.corridor_reach      = RST_CORRIDOR_LEN;
            shadow_cfg.corridor_half_width = RST_CORRIDOR_HALFW;
            shadow_cfg.trigger_count       = RST_TRIGGER_COUNT;
            hazard_cnt = '0;
            left_cnt   = '0;
            right_cnt  = '0;
            verdicts_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CHECK_ENABLE:   shadow_cfg.check_enable        = cfg_data[0];
                    REG_SENSOR_HEIGHT:  shadow_cfg.sensor_height       = cfg_data;
                    REG_ENV_TANGENT:    shadow_cfg.envelope_tangent    = cfg_data;
                    REG_CORRIDOR_LEN:   shadow_cfg.corridor_reach      = cfg_data[14:0];
                    REG_CORRIDOR_HALFW: shadow_cfg.corridor_half_width = cfg_data[14:0];
                    REG_TRIGGER_COUNT:  shadow_cfg.trigger_count       = cfg_data;
                    default: ;
                endcase
            end

            // Retire results before queuing new ones so the oldest is always matched first.
            if (m_tvalid && m_tready) begin
                got.side   = m_tdata[1:0];
                got.hazard = m_tdata[17:2];
                got.left   = m_tdata[33:18];
                got.right  = m_tdata[49:34];
                if (verdicts_due.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("unexpected result: side %0d hazard %0d left %0d right %0d",
                                 got.side, got.hazard, got.left, got.right);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.side !== want.side || got.hazard !== want.hazard ||
                        got.left !== want.left || got.right !== want.right) begin
                        error_cnt++;
                        if (error_cnt <= 10)
                            $display({"result differs: expected side %0d hazard %0d left %0d ",
                                      "right %0d, got side %0d hazard %0d left %0d right %0d"},
                                     want.side, want.hazard, want.left, want.right,
                                     got.side, got.hazard, got.left, got.right);
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                px = s_tdata[15:0];
                py = s_tdata[31:16];
                pz = s_tdata[47:32];
                if (shadow_cfg.check_enable && point_is_hazard(px, py, pz)) begin
                    hazard_cnt = bump(hazard_cnt);
                    if (py < 0)
                        right_cnt = bump(right_cnt);
                    else
                        left_cnt = bump(left_cnt);
                end
                if (s_tlast) begin
                    want.side = SIDE_NONE;
                    if (shadow_cfg.check_enable && hazard_cnt > shadow_cfg.trigger_count)
                        want.side = (left_cnt > right_cnt) ? SIDE_LEFT : SIDE_RIGHT;
                    want.hazard = hazard_cnt;
                    want.left   = left_cnt;
                    want.right  = right_cnt;
                    verdicts_due = {verdicts_due, want};
                    hazard_cnt = '0;
                    left_cnt   = '0;
                    right_cnt  = '0;
                end
            end
        end
        verdicts_pending <= verdicts_due.size();
        mismatches       <= error_cnt;
    end

endmodule

// ----- sim/lidar_envelope_collision_check_tb.sv -----
// Testbench top for the lidar envelope collision check: clock, reset, stimulus and verdict.
// Depends on lec_pkg, the block and lec_frame_verdict_checker.
module lidar_envelope_collision_check_tb;
    import lec_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_POINTS  = 75;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int verdicts_pending;
    int mismatches;
    bit tx_gaps     = 1'b1;
    bit rx_gaps     = 1'b1;
    int rx_hold     = 0;
    int idle_cycles = 0;

    // Current corridor, used only to aim the generated points.
    int cur_height  = RST_SENSOR_HEIGHT;
    int cur_tangent = RST_ENV_TANGENT;
    int cur_reach   = RST_CORRIDOR_LEN;
    int cur_half    = RST_CORRIDOR_HALFW;

    lidar_envelope_collision_check DUT (.*);

    lec_frame_verdict_checker checker_inst (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side back-pressure in random bursts.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
            rx_hold  <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("lidar_envelope_collision_check: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_point(input int x, input int y, input int z, input bit last);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z[15:0], y[15:0], x[15:0]};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the point stream until every frame result is back, then let the pipe empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Unused upper bits of the narrow registers carry noise; the block must drop them.
    task automatic apply_setting(input bit en, input int h, input int tan, input int reach,
                                 input int half, input int trig);
        drain();
        write_reg(REG_CHECK_ENABLE, {15'($urandom), en});
        write_reg(REG_SENSOR_HEIGHT, h[15:0]);
        write_reg(REG_ENV_TANGENT, tan[15:0]);
        write_reg(REG_CORRIDOR_LEN, {1'($urandom), reach[14:0]});
        write_reg(REG_CORRIDOR_HALFW, {1'($urandom), half[14:0]});
        write_reg(REG_TRIGGER_COUNT, trig[15:0]);
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_UNMAPPED_LO, 16'($urandom));
        cfg_valid   <= 1'b0;
        cur_height  = h;
        cur_tangent = tan;
        cur_reach   = reach;
        cur_half    = half;
    endtask

    // Mostly in-corridor points, with z aimed at the envelope edge, the extremes or noise.
    task automatic gen_point(output int x, output int y, output int z);
        int mode;
        int mag;
        mode = $urandom_range(0, 9);
        if (mode < 7 && cur_reach >= 2)
            x = $urandom_range(1, cur_reach - 1);
        else
            x = int'($urandom_range(0, 65535)) - 32768;
        if (mode < 7 && cur_half >= 1)
            y = int'($urandom_range(0, 2 * cur_half - 2)) - (cur_half - 1);
        else
            y = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 3))
            0: z = int'($urandom_range(0, 65535)) - 32768;
            1: begin
                mag = int'((longint'(x > 0 ? x : 1) * cur_tangent) >>> 16)
                      + int'($urandom_range(0, 1));
                z = (($urandom_range(0, 1) == 1) ? mag : -mag) - cur_height;
                if (z < -32768 || z > 32767)
                    z = int'($urandom_range(0, 65535)) - 32768;
            end
            2: z = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            default: z = int'($urandom_range(0, 1024)) - 512;
        endcase
    endtask

    initial begin : stimulus
        int x, y, z, flen, sent;
        bit leave_open, closing;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: corridor bounds, envelope edge on both signs of height + z.
        push_point(0, 0, 0, 0);
        push_point(-32768, 0, 32767, 0);
        push_point(1, 0, 32767, 0);
        push_point(1279, 255, -32768, 0);
        push_point(1280, 0, 32767, 0);
        push_point(256, -255, -126, 0);
        push_point(256, 0, -127, 0);
        push_point(256, -256, 32767, 0);
        push_point(256, 256, 32767, 0);
        push_point(256, -1, -264, 0);
        push_point(32767, -32768, 0, 1);
        drain();

        // Trigger at zero: left win, right win, tie, frame with no hazard point.
        write_reg(REG_TRIGGER_COUNT, 16'd0);
        write_reg(REG_UNMAPPED_HI, 16'hFFFF);
        cfg_valid <= 1'b0;
        push_point(100, 10, 0, 1);
        push_point(100, -10, 0, 1);
        push_point(100, 5, 0, 0);
        push_point(100, -5, 0, 1);
        push_point(100, 0, -195, 1);
        push_point(100, 1, 0, 0);
        push_point(100, 1, 0, 0);
        drain();

        // Disable mid-frame: the counts already taken must still be reported.
        write_reg(REG_CHECK_ENABLE, 16'hFFFE);
        cfg_valid <= 1'b0;
        push_point(100, 1, 0, 1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_setting(1'b1, -32768, 0, 32767, 32767, 0);
                1: apply_setting(1'b1, 32767, 65535, 0, 0, 65535);
                default: apply_setting($urandom_range(0, 5) != 0,
                    ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                : int'($urandom_range(0, 600)) - 300,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 40000),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(2, 3000),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(1, 800),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 25));
            endcase
            if (p == RANDOM_PHASES - 1) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end else begin
                tx_gaps = $urandom_range(0, 3) != 0;
                rx_gaps = $urandom_range(0, 3) != 0;
            end
            // Some phases end mid-frame so the next setting starts on live counts.
            leave_open = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_POINTS) begin
                flen = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
                if (flen > PHASE_POINTS - sent)
                    flen = PHASE_POINTS - sent;
                closing = (sent + flen < PHASE_POINTS) || !leave_open;
                for (int i = 0; i < flen; i++) begin
                    gen_point(x, y, z);
                    push_point(x, y, z, closing && (i == flen - 1));
                end
                sent += flen;
                if ($urandom_range(0, 11) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("lidar_envelope_collision_check: match");
        else
            $display("lidar_envelope_collision_check: mismatch");
        $finish;
    end

endmodule
